[src/phh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phh_pkg
// Shared types and constants of the position histogram and pair heatmap core.
// ----------------------------------------------------------------------------
package phh_pkg;

   localparam int COORD_BITS  = 32;
   localparam int CFG_BITS    = 31;
   localparam int CSR_IDX_BITS = 2;
   localparam int ROW_BITS    = 6;
   localparam int TBL_BITS    = 2;
   localparam int DATA_BITS   = 32;
   localparam int ITER_BITS   = 32;
   localparam int V_BITS      = 34;
   localparam int MUL_A_BITS  = 17;
   localparam int PROD_BITS   = 48;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PAIR_MODE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_RANGE    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INV_BIN_WIDTH = 2'd2;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [TBL_BITS-1:0] TBL_X    = 2'd0;
   localparam logic [TBL_BITS-1:0] TBL_Y    = 2'd1;
   localparam logic [TBL_BITS-1:0] TBL_Z    = 2'd2;
   localparam logic [TBL_BITS-1:0] TBL_HEAT = 2'd3;

   localparam logic [CFG_BITS-1:0] HALF_RANGE_RESET    = 31'd65536;
   localparam logic [CFG_BITS-1:0] INV_BIN_WIDTH_RESET = 31'd2097152;

   typedef struct packed {
      logic done;
      logic valid;
   } bin_status_type;

endpackage
`default_nettype wire

[src/phh_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phh_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module phh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

[src/phh_bin_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phh_bin_unit
// Bins one coordinate: offset, then two passes through one shared
// 17x31 multiplier, then floor and range check.
// ----------------------------------------------------------------------------
module phh_bin_unit #(
   parameter int BINS = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [phh_pkg::COORD_BITS-1:0] coord,
   input  wire logic signed [phh_pkg::COORD_BITS-1:0] ctr,
   input  wire logic [phh_pkg::CFG_BITS-1:0]          half_range,
   input  wire logic [phh_pkg::CFG_BITS-1:0]          inv_bin_width,
   output phh_pkg::bin_status_type                    status,
   output logic [$clog2(BINS)-1:0]                    bin
);

   localparam int BW = $clog2(BINS);
   localparam int QW = phh_pkg::PROD_BITS + 1 - 16;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_HI   = 4'b0010,
      B_LO   = 4'b0100,
      B_SUM  = 4'b1000
   } bstate_type;

   bstate_type state_ff, state_in;
   logic signed [phh_pkg::V_BITS-1:0] v_ff, v_in;
   logic [phh_pkg::PROD_BITS-1:0]     hi_ff, hi_in, lo_ff, lo_in;
   logic [phh_pkg::MUL_A_BITS-1:0]    mul_a;
   logic [phh_pkg::PROD_BITS-1:0]     prod;
   logic [phh_pkg::PROD_BITS:0]       sum;
   logic [QW-1:0]                     q;
   phh_pkg::bin_status_type           status_ff, status_in;
   logic [BW-1:0]                     bin_ff, bin_in;

   assign mul_a = (state_ff == B_HI) ? v_ff[32:16] : {1'b0, v_ff[15:0]};
   assign prod  = phh_pkg::PROD_BITS'(mul_a) * phh_pkg::PROD_BITS'(inv_bin_width);
   assign sum   = (phh_pkg::PROD_BITS+1)'(hi_ff) + (phh_pkg::PROD_BITS+1)'(lo_ff[46:16]);
   assign q     = sum[phh_pkg::PROD_BITS:16];

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      bin_in    = bin_ff;
      status_in = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               v_in = phh_pkg::V_BITS'(coord) - phh_pkg::V_BITS'(ctr)
                    + $signed({3'b000, half_range});
               state_in = B_HI;
            end
         end
         B_HI: begin
            hi_in    = prod;
            state_in = B_LO;
         end
         B_LO: begin
            lo_in    = prod;
            state_in = B_SUM;
         end
         B_SUM: begin
            status_in.done = 1'b1;
            if (inv_bin_width == '0) begin
               status_in.valid = 1'b1;
               bin_in          = '0;
            end else begin
               status_in.valid = !v_ff[phh_pkg::V_BITS-1] && (q < QW'(BINS));
               bin_in          = q[BW-1:0];
            end
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         status_ff <= '0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
      v_ff   <= v_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      bin_ff <= bin_in;
   end

   assign status = status_ff;
   assign bin    = bin_ff;

endmodule
`default_nettype wire

[src/position_histogram_pair_heatmap_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// position_histogram_pair_heatmap_core
// Particle position histograms with a pair heatmap, one shared binning unit.
// ----------------------------------------------------------------------------
// Start to rsp_valid: a read passes through S_RD_DATA; a pair particle does
// one heatmap read-modify-write per cell, for both cells of each of n stored
// earlier bins; a three-axis particle makes three passes through the binning unit.
// Busy holds for the whole transaction; rsp_valid is a one-cycle strobe.
// After reset a clearing pass over every address (next power of two per
// axis) zeroes the histogram and heatmap stores while busy is high.
module position_histogram_pair_heatmap_core #(
   parameter int BINS       = 64,
   parameter int PARTICLES  = 16,
   parameter int COUNT_BITS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic                                   req_type,
   input  wire logic signed [phh_pkg::COORD_BITS-1:0]  req_coord_x,
   input  wire logic signed [phh_pkg::COORD_BITS-1:0]  req_coord_y,
   input  wire logic signed [phh_pkg::COORD_BITS-1:0]  req_coord_z,
   input  wire logic signed [phh_pkg::COORD_BITS-1:0]  req_center,
   input  wire logic                                   req_last_particle,
   input  wire logic [phh_pkg::TBL_BITS-1:0]           req_read_table,
   input  wire logic [phh_pkg::ROW_BITS-1:0]           req_read_row,
   input  wire logic [phh_pkg::ROW_BITS-1:0]           req_read_col,
   output logic                                        rsp_valid,
   output logic [phh_pkg::DATA_BITS-1:0]               rsp_read_data,
   output logic [phh_pkg::ROW_BITS-1:0]                rsp_bin_x,
   output logic                                        rsp_bin_x_valid,
   output logic [phh_pkg::ITER_BITS-1:0]               rsp_iteration_count,
   input  wire logic                                   csr_we,
   input  wire logic [phh_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [phh_pkg::CFG_BITS-1:0]           csr_wdata
);

   localparam int BW  = $clog2(BINS);
   localparam int PW  = $clog2(PARTICLES);
   localparam int SW  = $clog2(PARTICLES + 1);
   localparam int CW  = COUNT_BITS;
   localparam int HW  = 2 * BW;
   localparam int RW  = (BW > phh_pkg::ROW_BITS) ? BW : phh_pkg::ROW_BITS;
   localparam int DW  = (CW > phh_pkg::DATA_BITS) ? CW : phh_pkg::DATA_BITS;
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [11:0] {
      S_CLEAR    = 12'b000000000001,
      S_IDLE     = 12'b000000000010,
      S_BIN_GO   = 12'b000000000100,
      S_BIN_WAIT = 12'b000000001000,
      S_HIST_RD  = 12'b000000010000,
      S_HIST_WR  = 12'b000000100000,
      S_PAIR_RDA = 12'b000001000000,
      S_PAIR_WRA = 12'b000010000000,
      S_PAIR_RDB = 12'b000100000000,
      S_PAIR_WRB = 12'b001000000000,
      S_FIN      = 12'b010000000000,
      S_RD_DATA  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic                          pair_ff, pair_in;
   logic [phh_pkg::CFG_BITS-1:0]  hr_ff, hr_in, ibw_ff, ibw_in;

   logic                                  last_ff, last_in;
   logic signed [phh_pkg::COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [phh_pkg::COORD_BITS-1:0] cz_ff, cz_in, cen_ff, cen_in;
   logic [phh_pkg::TBL_BITS-1:0]          tbl_ff, tbl_in;
   logic [phh_pkg::ROW_BITS-1:0]          row_ff, row_in, col_ff, col_in;

   logic [1:0]    axis_ff, axis_in;
   logic [BW-1:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic          vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [SW-1:0] k_ff, k_in, seen_ff, seen_in;
   logic [BW-1:0] earlier_ff [PARTICLES];
   logic          earlier_we;
   logic [BW-1:0] e_bin;
   logic [phh_pkg::ITER_BITS-1:0] iter_ff, iter_in;
   logic [HW-1:0] clr_ff, clr_in;

   logic                          rsp_valid_ff, rsp_valid_in, rsp_vx_ff, rsp_vx_in;
   logic [phh_pkg::DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [phh_pkg::ROW_BITS-1:0]  rsp_bx_ff, rsp_bx_in;
   logic [phh_pkg::ITER_BITS-1:0] rsp_iter_ff, rsp_iter_in;

   logic                                  bu_start;
   logic signed [phh_pkg::COORD_BITS-1:0] bu_coord, bu_ctr;
   phh_pkg::bin_status_type               bu_status;
   logic [BW-1:0]                         bu_bin;

   logic          hx_we, hy_we, hz_we, hm_we;
   logic [BW-1:0] hx_wa, hy_wa, hz_wa, hx_ra, hy_ra, hz_ra;
   logic [HW-1:0] hm_wa, hm_ra;
   logic [CW-1:0] hx_wd, hy_wd, hz_wd, hm_wd, hx_rd, hy_rd, hz_rd, hm_rd;

   logic [RW-1:0] row_w, col_w, bx_w;
   logic          row_ok, col_ok;
   logic [CW-1:0] sel_cnt;
   logic [DW-1:0] sel_w;

   assign row_w  = RW'(req_read_row);
   assign col_w  = RW'(req_read_col);
   assign bx_w   = RW'(bx_ff);
   assign row_ok = (32'(row_ff) < 32'(BINS));
   assign col_ok = (32'(col_ff) < 32'(BINS));
   assign e_bin  = earlier_ff[k_ff[PW-1:0]];

   always_comb begin
      case (axis_ff)
         AXIS_X:  bu_coord = cx_ff;
         AXIS_Y:  bu_coord = cy_ff;
         default: bu_coord = cz_ff;
      endcase
      if (axis_ff == AXIS_X) begin
         bu_ctr = pair_ff ? cen_ff : '0;
      end else if (axis_ff == AXIS_Z) begin
         bu_ctr = pair_ff ? '0 : cen_ff;
      end else begin
         bu_ctr = '0;
      end
   end

   always_comb begin
      case (tbl_ff)
         phh_pkg::TBL_X: sel_cnt = hx_rd;
         phh_pkg::TBL_Y: sel_cnt = hy_rd;
         phh_pkg::TBL_Z: sel_cnt = hz_rd;
         default:        sel_cnt = col_ok ? hm_rd : '0;
      endcase
      if (!row_ok) begin
         sel_cnt = '0;
      end
      sel_w = DW'(sel_cnt);
   end

   always_comb begin
      pair_in = pair_ff;
      hr_in   = hr_ff;
      ibw_in  = ibw_ff;
      if (csr_we) begin
         unique case (csr_index)
            phh_pkg::CSR_PAIR_MODE:     pair_in = csr_wdata[0];
            phh_pkg::CSR_HALF_RANGE:    hr_in   = csr_wdata;
            phh_pkg::CSR_INV_BIN_WIDTH: ibw_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      cen_in   = cen_ff;
      tbl_in   = tbl_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      axis_in  = axis_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      bz_in    = bz_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      vz_in    = vz_ff;
      k_in     = k_ff;
      seen_in  = seen_ff;
      iter_in  = iter_ff;
      clr_in   = clr_ff;
      earlier_we   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_bx_in    = rsp_bx_ff;
      rsp_vx_in    = rsp_vx_ff;
      rsp_iter_in  = rsp_iter_ff;
      bu_start = 1'b0;
      hx_we = 1'b0;
      hy_we = 1'b0;
      hz_we = 1'b0;
      hm_we = 1'b0;
      hx_wa = bx_ff;
      hy_wa = by_ff;
      hz_wa = bz_ff;
      hx_ra = bx_ff;
      hy_ra = by_ff;
      hz_ra = bz_ff;
      hx_wd = hx_rd + CW'(1);
      hy_wd = hy_rd + CW'(1);
      hz_wd = hz_rd + CW'(1);
      hm_wd = hm_rd + CW'(1);
      hm_wa = {bx_ff, e_bin};
      hm_ra = {bx_ff, e_bin};
      unique case (state_ff)
         S_CLEAR: begin
            hx_we = 1'b1;
            hy_we = 1'b1;
            hz_we = 1'b1;
            hm_we = 1'b1;
            hx_wa = clr_ff[BW-1:0];
            hy_wa = clr_ff[BW-1:0];
            hz_wa = clr_ff[BW-1:0];
            hm_wa = clr_ff;
            hx_wd = '0;
            hy_wd = '0;
            hz_wd = '0;
            hm_wd = '0;
            clr_in = clr_ff + HW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               last_in = req_last_particle;
               cx_in   = req_coord_x;
               cy_in   = req_coord_y;
               cz_in   = req_coord_z;
               cen_in  = req_center;
               tbl_in  = req_read_table;
               row_in  = req_read_row;
               col_in  = req_read_col;
               axis_in = AXIS_X;
               vx_in   = 1'b0;
               vy_in   = 1'b0;
               vz_in   = 1'b0;
               hx_ra   = row_w[BW-1:0];
               hy_ra   = row_w[BW-1:0];
               hz_ra   = row_w[BW-1:0];
               hm_ra   = {row_w[BW-1:0], col_w[BW-1:0]};
               if (req_type == phh_pkg::REQ_READ) begin
                  state_in = S_RD_DATA;
               end else begin
                  state_in = S_BIN_GO;
               end
            end
         end
         S_BIN_GO: begin
            bu_start = 1'b1;
            state_in = S_BIN_WAIT;
         end
         S_BIN_WAIT: begin
            if (bu_status.done) begin
               case (axis_ff)
                  AXIS_X: begin
                     bx_in = bu_bin;
                     vx_in = bu_status.valid;
                  end
                  AXIS_Y: begin
                     by_in = bu_bin;
                     vy_in = bu_status.valid;
                  end
                  default: begin
                     bz_in = bu_bin;
                     vz_in = bu_status.valid;
                  end
               endcase
               if (pair_ff || axis_ff == AXIS_Z) begin
                  state_in = S_HIST_RD;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = S_BIN_GO;
               end
            end
         end
         S_HIST_RD: begin
            state_in = S_HIST_WR;
         end
         S_HIST_WR: begin
            hx_we = vx_ff;
            hy_we = vy_ff;
            hz_we = vz_ff;
            k_in  = '0;
            if (pair_ff && vx_ff && seen_ff != '0) begin
               state_in = S_PAIR_RDA;
            end else begin
               state_in = S_FIN;
            end
         end
         S_PAIR_RDA: begin
            state_in = S_PAIR_WRA;
         end
         S_PAIR_WRA: begin
            hm_we    = 1'b1;
            state_in = S_PAIR_RDB;
         end
         S_PAIR_RDB: begin
            hm_ra    = {e_bin, bx_ff};
            state_in = S_PAIR_WRB;
         end
         S_PAIR_WRB: begin
            hm_we = 1'b1;
            hm_wa = {e_bin, bx_ff};
            k_in  = k_ff + SW'(1);
            if (k_ff + SW'(1) == seen_ff) begin
               state_in = S_FIN;
            end else begin
               state_in = S_PAIR_RDA;
            end
         end
         S_FIN: begin
            if (pair_ff && vx_ff && seen_ff < SW'(PARTICLES)) begin
               earlier_we = 1'b1;
               seen_in    = seen_ff + SW'(1);
            end
            if (last_ff) begin
               iter_in = iter_ff + phh_pkg::ITER_BITS'(1);
               seen_in = '0;
            end
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_bx_in    = vx_ff ? bx_w[phh_pkg::ROW_BITS-1:0] : '0;
            rsp_vx_in    = vx_ff;
            rsp_iter_in  = last_ff ? iter_ff + phh_pkg::ITER_BITS'(1) : iter_ff;
            state_in     = S_IDLE;
         end
         S_RD_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = sel_w[phh_pkg::DATA_BITS-1:0];
            rsp_bx_in    = '0;
            rsp_vx_in    = 1'b0;
            rsp_iter_in  = iter_ff;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pair_ff      <= 1'b1;
         hr_ff        <= phh_pkg::HALF_RANGE_RESET;
         ibw_ff       <= phh_pkg::INV_BIN_WIDTH_RESET;
         seen_ff      <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pair_ff      <= pair_in;
         hr_ff        <= hr_in;
         ibw_ff       <= ibw_in;
         seen_ff      <= seen_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      cen_ff      <= cen_in;
      tbl_ff      <= tbl_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      axis_ff     <= axis_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      bz_ff       <= bz_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      vz_ff       <= vz_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bx_ff   <= rsp_bx_in;
      rsp_vx_ff   <= rsp_vx_in;
      rsp_iter_ff <= rsp_iter_in;
      if (earlier_we) begin
         earlier_ff[seen_ff[PW-1:0]] <= bx_ff;
      end
   end

   phh_bin_unit #(
      .BINS (BINS)
   ) u_bin (
      .clock         (clock),
      .reset         (reset),
      .start         (bu_start),
      .coord         (bu_coord),
      .ctr           (bu_ctr),
      .half_range    (hr_ff),
      .inv_bin_width (ibw_ff),
      .status        (bu_status),
      .bin           (bu_bin)
   );

   phh_ram #(.WIDTH(CW), .DEPTH(1 << BW)) u_hist_x (
      .clock (clock), .we (hx_we), .waddr (hx_wa), .wdata (hx_wd),
      .raddr (hx_ra), .rdata (hx_rd)
   );

   phh_ram #(.WIDTH(CW), .DEPTH(1 << BW)) u_hist_y (
      .clock (clock), .we (hy_we), .waddr (hy_wa), .wdata (hy_wd),
      .raddr (hy_ra), .rdata (hy_rd)
   );

   phh_ram #(.WIDTH(CW), .DEPTH(1 << BW)) u_hist_z (
      .clock (clock), .we (hz_we), .waddr (hz_wa), .wdata (hz_wd),
      .raddr (hz_ra), .rdata (hz_rd)
   );

   phh_ram #(.WIDTH(CW), .DEPTH(1 << HW)) u_heat (
      .clock (clock), .we (hm_we), .waddr (hm_wa), .wdata (hm_wd),
      .raddr (hm_ra), .rdata (hm_rd)
   );

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_data_ff;
   assign rsp_bin_x           = rsp_bx_ff;
   assign rsp_bin_x_valid     = rsp_vx_ff;
   assign rsp_iteration_count = rsp_iter_ff;

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid)
      else $error("response during clearing pass");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SW'(PARTICLES))
      else $error("stored particle count over limit");

endmodule
`default_nettype wire
